/* sv/vsc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Stick constraint package
// Shared constants for the stick constraint block and its checker.
// ----------------------------------------------------------------------------
package vsc_pkg;

  localparam int IDX_W      = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // Register select, taken from the word address bit of paddr.
  localparam logic REG_AREA_WIDTH  = 1'b0;
  localparam logic REG_AREA_HEIGHT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] AREA_WIDTH_RST  = 32'd204800;
  localparam logic [CFG_DATA_W-1:0] AREA_HEIGHT_RST = 32'd153600;

endpackage
`default_nettype wire

/* sv/vsc_sqrt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per register stage, most significant bit first.
// ----------------------------------------------------------------------------
module vsc_sqrt #(
  parameter int W = 20
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [2*W:0]   rad,
  output      logic [W:0]     root
);

  localparam int N  = W + 1;
  localparam int RW = 2 * W + 2;

  logic [RW-1:0] rem_r  [N];
  logic [W:0]    root_r [N];

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_stage
      localparam int B = W - k;
      logic [RW-1:0] rem_in;
      logic [W:0]    root_in;
      logic [RW-1:0] trial;
      logic [RW-1:0] rem_nxt;
      logic [W:0]    root_nxt;

      if (k == 0) begin : g_first
        assign rem_in  = RW'(rad);
        assign root_in = '0;
      end else begin : g_rest
        assign rem_in  = rem_r[k-1];
        assign root_in = root_r[k-1];
      end

      // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B); r has no bits at or below B.
      assign trial = (RW'(root_in) << (B + 1)) | (RW'(1) << (2 * B));

      always_comb begin
        rem_nxt  = rem_in;
        root_nxt = root_in;
        if (rem_in >= trial) begin
          rem_nxt  = rem_in - trial;
          root_nxt = root_in | ((W + 1)'(1) << B);
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k]  <= rem_nxt;
          root_r[k] <= root_nxt;
        end
      end
    end
  endgenerate

  assign root = root_r[N-1];

endmodule
`default_nettype wire

/* sv/vsc_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Produces the low W quotient bits, one per stage. The caller ensures that
// num is below den shifted up by W, or ignores the quotient.
// ----------------------------------------------------------------------------
module vsc_div #(
  parameter int W = 20
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [2*W+1:0] num,
  input  wire logic [W+1:0]   den,
  output      logic [W-1:0]   quo
);

  logic [W+1:0] rem_r [W];
  logic [W-1:0] low_r [W];
  logic [W+1:0] den_r [W];
  logic [W-1:0] q_r   [W];

  genvar k;
  generate
    for (k = 0; k < W; k++) begin : g_stage
      logic [W+1:0] rem_in;
      logic [W-1:0] low_in;
      logic [W+1:0] den_in;
      logic [W-1:0] q_in;
      logic [W+2:0] t;
      logic         ge;

      if (k == 0) begin : g_first
        assign rem_in = num[2*W+1:W];
        assign low_in = num[W-1:0];
        assign den_in = den;
        assign q_in   = '0;
      end else begin : g_rest
        assign rem_in = rem_r[k-1];
        assign low_in = low_r[k-1];
        assign den_in = den_r[k-1];
        assign q_in   = q_r[k-1];
      end

      assign t  = {rem_in, low_in[W-1]};
      assign ge = (t >= {1'b0, den_in});

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? (W + 2)'(t - {1'b0, den_in}) : t[W+1:0];
          low_r[k] <= low_in << 1;
          den_r[k] <= den_in;
          q_r[k]   <= {q_in[W-2:0], ge};
        end
      end
    end
  endgenerate

  assign quo = q_r[W-1];

endmodule
`default_nettype wire

/* sv/verlet_stick_constraint.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Verlet stick constraint
// Computes the distance correction for one stick per word.
// ----------------------------------------------------------------------------
// The block takes one stick per clock unless the output stalls. The offset to
// add to the first point and to subtract from the second point comes out of
// the last pipeline stage. Most of the pipeline depth comes from the square
// root, which resolves one bit per stage (COORD_WIDTH+1 stages), and from the
// two dividers, which resolve one quotient bit per stage (COORD_WIDTH stages).
// The sustained rate is one word per cycle unless stalled. The whole pipeline
// advances together; it holds only while a finished result waits at the output
// and out_ready is low, so in_ready equals out_ready or an empty output stage.
// The offset is (rest - distance) * d / (2 * distance), rounded half up in
// magnitude, saturated to the coordinate range and then clamped so that the
// first point stays inside the configured area. Coincident points give a zero
// offset before the clamp and raise out_zero_distance. Configuration registers
// sit at byte address 0 (area width) and 4 (area height). The clamp reads them
// near the end of the pipeline, so they should be written only while no word
// is in flight.
// ----------------------------------------------------------------------------
module verlet_stick_constraint
  import vsc_pkg::*;
#(
  parameter int COORD_WIDTH = 20
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Input channel
  input  wire logic                   in_valid,
  output      logic                   in_ready,
  input  wire logic [IDX_W-1:0]       in_first_index,
  input  wire logic [IDX_W-1:0]       in_second_index,
  input  wire logic [COORD_WIDTH-1:0] in_first_x,
  input  wire logic [COORD_WIDTH-1:0] in_first_y,
  input  wire logic [COORD_WIDTH-1:0] in_second_x,
  input  wire logic [COORD_WIDTH-1:0] in_second_y,
  input  wire logic [COORD_WIDTH-1:0] in_rest_length,
  // Result channel
  output      logic                   out_valid,
  input  wire logic                   out_ready,
  output      logic [IDX_W-1:0]       out_first_index,
  output      logic [IDX_W-1:0]       out_second_index,
  output      logic [COORD_WIDTH:0]   out_offset_x,
  output      logic [COORD_WIDTH:0]   out_offset_y,
  output      logic                   out_zero_distance,
  // Configuration port
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [CFG_ADDR_W-1:0]  paddr,
  input  wire logic [CFG_DATA_W-1:0]  pwdata,
  output      logic [CFG_DATA_W-1:0]  prdata,
  output      logic                   pready
);

  localparam int W = COORD_WIDTH;
  // Stage numbers of the pipeline, counted from the input register.
  localparam int ST_EXC  = W + 4;
  localparam int ST_DIVO = 2 * W + 7;
  localparam int D       = 2 * W + 10;
  localparam int LT_N    = ST_DIVO - ST_EXC + 1;

  typedef struct packed {
    logic [IDX_W-1:0] fi;
    logic [IDX_W-1:0] si;
    logic [W-1:0]     fx;
    logic [W-1:0]     fy;
    logic [W-1:0]     rest;
    logic [W-1:0]     adx;
    logic [W-1:0]     ady;
    logic             nx;
    logic             ny;
  } pl_t;

  typedef struct packed {
    logic exneg;
    logic zero;
  } lt_t;

  // Configuration registers.
  logic [W-1:0] area_w_r;
  logic [W-1:0] area_h_r;
  logic         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_w_r <= W'(AREA_WIDTH_RST);
      area_h_r <= W'(AREA_HEIGHT_RST);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_AREA_WIDTH) begin
        area_w_r <= pwdata[W-1:0];
      end else begin
        area_h_r <= pwdata[W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_AREA_WIDTH) begin
      prdata[W-1:0] = area_w_r;
    end else begin
      prdata[W-1:0] = area_h_r;
    end
  end

  // The pipeline moves as a whole whenever the output stage can be refilled.
  logic en;
  logic v_r [D];

  assign en       = out_ready | ~v_r[D-1];
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < D; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < D; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  // Stage 0: register the stick with absolute coordinate differences.
  pl_t pl_nxt;
  pl_t pl_r [D];

  always_comb begin
    pl_nxt.fi   = in_first_index;
    pl_nxt.si   = in_second_index;
    pl_nxt.fx   = in_first_x;
    pl_nxt.fy   = in_first_y;
    pl_nxt.rest = in_rest_length;
    pl_nxt.nx   = in_first_x < in_second_x;
    pl_nxt.ny   = in_first_y < in_second_y;
    pl_nxt.adx  = pl_nxt.nx ? in_second_x - in_first_x : in_first_x - in_second_x;
    pl_nxt.ady  = pl_nxt.ny ? in_second_y - in_first_y : in_first_y - in_second_y;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r[0] <= pl_nxt;
      for (int i = 1; i < D; i++) begin
        pl_r[i] <= pl_r[i-1];
      end
    end
  end

  // Stages 1 and 2: squares, then their sum.
  logic [2*W-1:0] sqx_r;
  logic [2*W-1:0] sqy_r;
  logic [2*W:0]   sum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r <= pl_r[0].adx * pl_r[0].adx;
      sqy_r <= pl_r[0].ady * pl_r[0].ady;
      sum_r <= (2 * W + 1)'(sqx_r) + (2 * W + 1)'(sqy_r);
    end
  end

  // Square root: the floor of the distance, W+1 bits.
  logic [W:0] root;

  vsc_sqrt #(.W(W)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (sum_r),
    .root (root)
  );

  // Excess of the rest length over the distance, as sign and magnitude.
  logic [W:0] dist_r;
  logic [W:0] aex_r;
  lt_t        lt_nxt;
  lt_t        lt_r [LT_N];

  always_comb begin
    lt_nxt.exneg = {1'b0, pl_r[ST_EXC-1].rest} < root;
    lt_nxt.zero  = (root == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= root;
      aex_r  <= lt_nxt.exneg ? root - {1'b0, pl_r[ST_EXC-1].rest}
                             : {1'b0, pl_r[ST_EXC-1].rest} - root;
      lt_r[0] <= lt_nxt;
      for (int i = 1; i < LT_N; i++) begin
        lt_r[i] <= lt_r[i-1];
      end
    end
  end

  // Products with the coordinate differences, then the rounding term.
  logic [2*W:0]   px_r;
  logic [2*W:0]   py_r;
  logic [W:0]     dist_m_r;
  logic [2*W+1:0] numx_r;
  logic [2*W+1:0] numy_r;
  logic [W+1:0]   den_r;
  logic [2*W+1:0] numx_c_r;
  logic [2*W+1:0] numy_c_r;
  logic [W+1:0]   den_c_r;
  logic           satx_c_r;
  logic           saty_c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px_r     <= aex_r * pl_r[ST_EXC].adx;
      py_r     <= aex_r * pl_r[ST_EXC].ady;
      dist_m_r <= dist_r;
      numx_r   <= (2 * W + 2)'(px_r) + (2 * W + 2)'(dist_m_r);
      numy_r   <= (2 * W + 2)'(py_r) + (2 * W + 2)'(dist_m_r);
      den_r    <= {dist_m_r, 1'b0};
      // A quotient of 2^W or more saturates; the divider then only needs W bits.
      satx_c_r <= numx_r >= {den_r, {W{1'b0}}};
      saty_c_r <= numy_r >= {den_r, {W{1'b0}}};
      numx_c_r <= numx_r;
      numy_c_r <= numy_r;
      den_c_r  <= den_r;
    end
  end

  logic [W-1:0] qx;
  logic [W-1:0] qy;

  vsc_div #(.W(W)) u_div_x (
    .clk (clk),
    .en  (en),
    .num (numx_c_r),
    .den (den_c_r),
    .quo (qx)
  );

  vsc_div #(.W(W)) u_div_y (
    .clk (clk),
    .en  (en),
    .num (numy_c_r),
    .den (den_c_r),
    .quo (qy)
  );

  // Saturation flags wait alongside the dividers.
  logic [1:0] sat_r [W];

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r[0] <= {satx_c_r, saty_c_r};
      for (int i = 1; i < W; i++) begin
        sat_r[i] <= sat_r[i-1];
      end
    end
  end

  // Signed offset before the clamp.
  logic [W-1:0] magx;
  logic [W-1:0] magy;
  logic [W:0]   offx_r;
  logic [W:0]   offy_r;
  logic         zero_o_r;
  lt_t          lt_o;

  assign lt_o = lt_r[LT_N-1];
  assign magx = sat_r[W-1][1] ? '1 : qx;
  assign magy = sat_r[W-1][0] ? '1 : qy;

  always_ff @(posedge clk) begin
    if (en) begin
      zero_o_r <= lt_o.zero;
      if (lt_o.zero) begin
        offx_r <= '0;
        offy_r <= '0;
      end else begin
        offx_r <= (lt_o.exneg ^ pl_r[ST_DIVO].nx) ? (W + 1)'(0) - {1'b0, magx}
                                                  : {1'b0, magx};
        offy_r <= (lt_o.exneg ^ pl_r[ST_DIVO].ny) ? (W + 1)'(0) - {1'b0, magy}
                                                  : {1'b0, magy};
      end
    end
  end

  // Clamp so the first point lands inside [0, bound] on each axis.
  function automatic logic [W:0] clamp_axis(logic [W:0] off, logic [W-1:0] pos,
                                            logic [W-1:0] bound);
    logic signed [W+1:0] moved;
    moved = $signed({2'b00, pos}) + $signed({off[W], off});
    if (moved > $signed({2'b00, bound})) begin
      clamp_axis = {1'b0, bound} - {1'b0, pos};
    end else if (moved < 0) begin
      clamp_axis = (W + 1)'(0) - {1'b0, pos};
    end else begin
      clamp_axis = off;
    end
  endfunction

  logic [W:0] outx_r;
  logic [W:0] outy_r;
  logic       outz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      outx_r <= clamp_axis(offx_r, pl_r[D-2].fx, area_w_r);
      outy_r <= clamp_axis(offy_r, pl_r[D-2].fy, area_h_r);
      outz_r <= zero_o_r;
    end
  end

  assign out_valid         = v_r[D-1];
  assign out_first_index   = pl_r[D-1].fi;
  assign out_second_index  = pl_r[D-1].si;
  assign out_offset_x      = outx_r;
  assign out_offset_y      = outy_r;
  assign out_zero_distance = outz_r;

endmodule
`default_nettype wire

/* sv/vsc_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Stick constraint port checker
// Watches the top level's ports and is bound to every instance.
// ----------------------------------------------------------------------------
module vsc_checker
  import vsc_pkg::*;
#(
  parameter int COORD_WIDTH = 20
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [COORD_WIDTH:0] out_offset_x,
  input wire logic [COORD_WIDTH:0] out_offset_y,
  input wire logic                 pready
);

  localparam logic [COORD_WIDTH:0] MOST_NEG = {1'b1, {COORD_WIDTH{1'b0}}};

  // A waiting result is not dropped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // The input side stalls only behind a waiting result.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (out_ready || !out_valid))
    else $error("input stalled without a waiting result");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word after reset");

  // Offsets are saturated magnitudes and never reach the most negative code.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_offset_x != MOST_NEG) && (out_offset_y != MOST_NEG))
    else $error("offset outside its range");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("configuration port not ready");

endmodule

bind verlet_stick_constraint vsc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_vsc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_offset_x (out_offset_x),
  .out_offset_y (out_offset_y),
  .pready       (pready)
);
`default_nettype wire

/* tb/testbench.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Stick constraint testbench
// Streams sticks through the block and compares every returned offset with an
// in-bench prediction: the floor of the distance, the rounded and saturated
// correction, and the area clamp. Boundaries are swept over the APB port.
// ----------------------------------------------------------------------------
module testbench;
  import vsc_pkg::*;

  localparam int COORD_WIDTH = 20;
  localparam longint COORD_MAX = (64'sd1 << COORD_WIDTH) - 1;
  // Pipeline depth is 2*COORD_WIDTH+10; the settle wait leaves ample margin.
  localparam int SETTLE_CYCLES = 2 * (2 * COORD_WIDTH + 10);
  localparam longint CYCLE_LIMIT = 1_000_000;

  // Byte addresses of the two boundary registers.
  localparam logic [CFG_ADDR_W-1:0] ADDR_AREA_WIDTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_AREA_HEIGHT = 3'd4;

  typedef struct packed {
    logic [IDX_W-1:0]       first_index;
    logic [IDX_W-1:0]       second_index;
    logic [COORD_WIDTH-1:0] first_x;
    logic [COORD_WIDTH-1:0] first_y;
    logic [COORD_WIDTH-1:0] second_x;
    logic [COORD_WIDTH-1:0] second_y;
    logic [COORD_WIDTH-1:0] rest_length;
  } stick_t;

  typedef struct packed {
    logic [IDX_W-1:0]     first_index;
    logic [IDX_W-1:0]     second_index;
    logic [COORD_WIDTH:0] offset_x;
    logic [COORD_WIDTH:0] offset_y;
    logic                 zero_distance;
  } correction_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [IDX_W-1:0]       in_first_index = '0;
  logic [IDX_W-1:0]       in_second_index = '0;
  logic [COORD_WIDTH-1:0] in_first_x = '0;
  logic [COORD_WIDTH-1:0] in_first_y = '0;
  logic [COORD_WIDTH-1:0] in_second_x = '0;
  logic [COORD_WIDTH-1:0] in_second_y = '0;
  logic [COORD_WIDTH-1:0] in_rest_length = '0;

  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [IDX_W-1:0]       out_first_index;
  logic [IDX_W-1:0]       out_second_index;
  logic [COORD_WIDTH:0]   out_offset_x;
  logic [COORD_WIDTH:0]   out_offset_y;
  logic                   out_zero_distance;

  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  paddr = '0;
  logic [CFG_DATA_W-1:0]  pwdata = '0;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;

  verlet_stick_constraint #(.COORD_WIDTH(COORD_WIDTH)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_first_index(in_first_index), .in_second_index(in_second_index),
    .in_first_x(in_first_x), .in_first_y(in_first_y),
    .in_second_x(in_second_x), .in_second_y(in_second_y),
    .in_rest_length(in_rest_length),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_first_index(out_first_index), .out_second_index(out_second_index),
    .out_offset_x(out_offset_x), .out_offset_y(out_offset_y),
    .out_zero_distance(out_zero_distance),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The bench keeps its own copy of the two boundaries. They only change
  // while the pipeline is empty, so predicting at acceptance is safe.
  longint area_w = 204800;
  longint area_h = 153600;

  correction_t pending_corrections[$];
  int  error_count = 0;
  int  checked_count = 0;
  int  zero_seen = 0;
  int  clamp_seen = 0;
  int  sat_seen = 0;
  int  hold_request = 0;
  longint cycle_count = 0;

  // Keeps the first point inside [0, bound] once the offset is applied.
  function automatic longint clamp_to_area(longint off, longint pos, longint bound);
    longint moved;
    moved = pos + off;
    if (moved > bound) return bound - pos;
    if (moved < 0) return -pos;
    return off;
  endfunction

  // Predicts the correction for one stick: floor square root of the squared
  // distance, half-up rounded quotient, saturation, then the area clamp.
  function automatic correction_t predict_correction(stick_t s);
    longint fx, fy, dx, dy, adx, ady, sq, cur_len, t, excess, aex, mx, my;
    longint offx, offy, cx, cy;
    correction_t r;
    fx = s.first_x;
    fy = s.first_y;
    dx = fx - longint'(s.second_x);
    dy = fy - longint'(s.second_y);
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    sq = adx * adx + ady * ady;
    cur_len = 0;
    for (int b = COORD_WIDTH + 1; b >= 0; b--) begin
      t = cur_len | (64'sd1 << b);
      if (t * t <= sq) cur_len = t;
    end
    offx = 0;
    offy = 0;
    if (cur_len != 0) begin
      excess = longint'(s.rest_length) - cur_len;
      aex = excess < 0 ? -excess : excess;
      mx = (aex * adx + cur_len) / (2 * cur_len);
      my = (aex * ady + cur_len) / (2 * cur_len);
      if (mx > COORD_MAX || my > COORD_MAX) sat_seen++;
      if (mx > COORD_MAX) mx = COORD_MAX;
      if (my > COORD_MAX) my = COORD_MAX;
      offx = ((excess < 0) != (dx < 0)) ? -mx : mx;
      offy = ((excess < 0) != (dy < 0)) ? -my : my;
    end else begin
      zero_seen++;
    end
    cx = clamp_to_area(offx, fx, area_w);
    cy = clamp_to_area(offy, fy, area_h);
    if (cx != offx || cy != offy) clamp_seen++;
    r.first_index = s.first_index;
    r.second_index = s.second_index;
    r.offset_x = cx[COORD_WIDTH:0];
    r.offset_y = cy[COORD_WIDTH:0];
    r.zero_distance = (cur_len == 0);
    return r;
  endfunction

  // Every accepted stick queues its predicted correction.
  always @(posedge clk) begin
    stick_t s;
    if (rst_n && in_valid && in_ready) begin
      s = '{in_first_index, in_second_index, in_first_x, in_first_y,
            in_second_x, in_second_y, in_rest_length};
      pending_corrections.push_back(predict_correction(s));
    end
  end

  // Every accepted result is compared with the oldest prediction.
  always @(posedge clk) begin
    correction_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_corrections.size() == 0) begin
        $display("%0t: unexpected word idx %h/%h", $time, out_first_index,
                 out_second_index);
        error_count++;
      end else begin
        want = pending_corrections.pop_front();
        checked_count++;
        if (out_first_index !== want.first_index) begin
          $display("%0t: first_index expected %h got %h", $time,
                   want.first_index, out_first_index);
          error_count++;
        end
        if (out_second_index !== want.second_index) begin
          $display("%0t: second_index expected %h got %h", $time,
                   want.second_index, out_second_index);
          error_count++;
        end
        if (out_offset_x !== want.offset_x) begin
          $display("%0t: offset_x expected %h got %h", $time, want.offset_x,
                   out_offset_x);
          error_count++;
        end
        if (out_offset_y !== want.offset_y) begin
          $display("%0t: offset_y expected %h got %h", $time, want.offset_y,
                   out_offset_y);
          error_count++;
        end
        if (out_zero_distance !== want.zero_distance) begin
          $display("%0t: zero_distance expected %b got %b", $time,
                   want.zero_distance, out_zero_distance);
          error_count++;
        end
      end
    end
  end

  // Receiver. A requested hold is counted out here, cycle by cycle, while
  // the sender keeps pushing. Otherwise the stall pattern switches now and
  // then between always ready, light stalls and heavier stalls.
  int hold_left = 0;
  int rx_mode = 0;
  always @(posedge clk) begin
    int r;
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if ($urandom_range(0, 299) == 0) rx_mode = $urandom_range(0, 2);
    r = $urandom_range(0, 99);
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_mode == 0) begin
      out_ready <= 1'b1;
    end else if (rx_mode == 1) begin
      out_ready <= (r >= 15);
    end else begin
      out_ready <= (r >= 50);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("verlet_stick_constraint verification failed");
      $finish;
    end
  end

  // Gap length: mostly none, often short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one word and holds it until it is taken. Valid is lowered only
  // when a gap follows, so back-to-back words keep it high.
  task automatic send_stick(stick_t s, bit allow_gap);
    int gap;
    in_valid        <= 1'b1;
    in_first_index  <= s.first_index;
    in_second_index <= s.second_index;
    in_first_x      <= s.first_x;
    in_first_y      <= s.first_y;
    in_second_x     <= s.second_x;
    in_second_y     <= s.second_y;
    in_rest_length  <= s.rest_length;
    do @(posedge clk); while (!(in_valid && in_ready));
    gap = allow_gap ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lowers valid, waits for every prediction to be matched, then lets the
  // pipeline settle before anything touches the registers.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_corrections.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup and access phases, then the bus returns to idle.
  task automatic write_area(logic [CFG_ADDR_W-1:0] addr, longint value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_AREA_WIDTH) area_w = value;
    else area_h = value;
    @(posedge clk);
  endtask

  task automatic set_area(longint w, longint h);
    write_area(ADDR_AREA_WIDTH, w);
    write_area(ADDR_AREA_HEIGHT, h);
  endtask

  function automatic stick_t make_stick(longint fx, longint fy, longint sx,
                                        longint sy, longint rest);
    stick_t s;
    s.first_index  = IDX_W'($urandom);
    s.second_index = IDX_W'($urandom);
    s.first_x  = COORD_WIDTH'(fx);
    s.first_y  = COORD_WIDTH'(fy);
    s.second_x = COORD_WIDTH'(sx);
    s.second_y = COORD_WIDTH'(sy);
    s.rest_length = COORD_WIDTH'(rest);
    return s;
  endfunction

  // Random stick. Most sticks are short and sit near the area, where the
  // correction is small and the clamp matters; some span the full range.
  function automatic stick_t random_stick();
    longint fx, fy, sx, sy, rest, span;
    int mode;
    mode = $urandom_range(0, 99);
    if (mode < 65) begin
      fx = $urandom_range(0, 215000);
      fy = $urandom_range(0, 165000);
      span = ($urandom_range(0, 3) == 0) ? 60000 : 3000;
      sx = fx + longint'($urandom_range(0, 2 * span)) - span;
      sy = fy + longint'($urandom_range(0, 2 * span)) - span;
      if (sx < 0) sx = 0;
      if (sy < 0) sy = 0;
      if (sx > COORD_MAX) sx = COORD_MAX;
      if (sy > COORD_MAX) sy = COORD_MAX;
      rest = $urandom_range(0, 2 * span);
    end else if (mode < 70) begin
      fx = $urandom_range(0, COORD_MAX);
      fy = $urandom_range(0, COORD_MAX);
      sx = fx;
      sy = fy;
      rest = $urandom_range(0, COORD_MAX);
    end else begin
      fx = $urandom_range(0, COORD_MAX);
      fy = $urandom_range(0, COORD_MAX);
      sx = $urandom_range(0, COORD_MAX);
      sy = $urandom_range(0, COORD_MAX);
      rest = $urandom_range(0, COORD_MAX);
    end
    return make_stick(fx, fy, sx, sy, rest);
  endfunction

  // Extremes and the named special cases, at the reset boundaries.
  task automatic test_directed();
    stick_t s;
    // Coincident points at the origin and at the top of the range; the
    // second one also sits outside the area and must be pulled back.
    send_stick(make_stick(0, 0, 0, 0, 0), 1);
    s = make_stick(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    s.first_index = '1;
    s.second_index = '1;
    send_stick(s, 1);
    s = make_stick(1000, 1000, 1000, 1000, 500);
    s.first_index = '0;
    s.second_index = '0;
    send_stick(s, 0);
    // Large corrections from long rest lengths or long sticks, below saturation.
    send_stick(make_stick(100000, 100000, 100001, 100000, COORD_MAX), 0);
    send_stick(make_stick(1, 1, 0, 0, COORD_MAX), 0);
    send_stick(make_stick(0, 0, COORD_MAX, COORD_MAX, 0), 0);
    // Stretched and compressed sticks, and one at its rest length, in several directions.
    send_stick(make_stick(50000, 50000, 60000, 50000, 2560), 1);
    send_stick(make_stick(60000, 50000, 50000, 50000, 2560), 1);
    send_stick(make_stick(50000, 60000, 50000, 50000, 20000), 1);
    send_stick(make_stick(50000, 50000, 53000, 54000, 5000), 1);
    send_stick(make_stick(50000, 50000, 51000, 49000, 256), 0);
    // Rounding half up on odd spans.
    send_stick(make_stick(3, 0, 0, 0, 0), 0);
    send_stick(make_stick(0, 5, 0, 0, 8), 0);
    // First point already past each boundary.
    send_stick(make_stick(204801, 1000, 204900, 1000, 100), 1);
    send_stick(make_stick(1000, 153700, 1000, 153800, 100), 1);
    send_stick(make_stick(COORD_MAX, COORD_MAX, 0, 0, 0), 1);
    // Corrections pushing across the left, top, right and bottom edges.
    send_stick(make_stick(100, 100, 5000, 5000, 100000), 1);
    send_stick(make_stick(204700, 153500, 200000, 150000, 100000), 1);
    send_stick(make_stick(204800, 153600, 204800, 153600, 10), 1);
    drain();
  endtask

  // A long hold on the result side while words keep coming, so the pipeline
  // fills and the block has to refuse input.
  task automatic test_backpressure();
    hold_request = 300;
    for (int i = 0; i < 80; i++) send_stick(random_stick(), 0);
    drain();
  endtask

  // Boundaries at both extremes and at random values, each with a batch.
  task automatic test_area_sweep();
    longint widths[5], heights[5];
    widths  = '{0, COORD_MAX, 204800, 0, 0};
    heights = '{COORD_MAX, 0, 0, 153600, 0};
    widths[4]  = $urandom_range(0, COORD_MAX);
    heights[4] = $urandom_range(0, 200000);
    for (int p = 0; p < 5; p++) begin
      set_area(widths[p], heights[p]);
      for (int i = 0; i < 60; i++) send_stick(random_stick(), 1);
      drain();
    end
    set_area(204800, 153600);
  endtask

  // The bulk of the stream at the default area, in phases with pauses.
  task automatic test_random_stream();
    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < 250; i++) send_stick(random_stick(), 1);
      drain();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_area_sweep();
    test_random_stream();
    drain();
    $display("Checked %0d corrections: %0d coincident, %0d clamped, %0d saturated.",
             checked_count, zero_seen, clamp_seen, sat_seen);
    $display("Boundary registers swept through both extremes, with stalls on both sides.");
    if (error_count == 0 && pending_corrections.size() == 0) begin
      $display("verlet_stick_constraint verification clean");
    end else begin
      $display("verlet_stick_constraint verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* verlet_stick_constraint.f */
sv/vsc_pkg.sv
sv/vsc_sqrt.sv
sv/vsc_div.sv
sv/verlet_stick_constraint.sv
sv/vsc_checker.sv
tb/testbench.sv
